// ===== rtl/assert_macros.svh =====
// assertion helpers used by alm_back, clocked on clk and gated by rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ALM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ALM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/alm_pkg.sv =====
package alm_pkg;

  localparam int NumChannelsDef = 8;
  localparam int AddrW = 5;

  localparam logic signed [15:0] MINF = 16'sh8000;

  localparam logic [23:0] DecayRateRst = 24'd197286;
  localparam logic [15:0] IntGainRst = 16'd216;
  localparam logic [23:0] PeakHoldRst = 24'd20000;
  localparam logic [23:0] InputHoldRst = 24'd1000;
  localparam logic [15:0] IdleTimeoutRst = 16'd500;
  localparam logic signed [15:0] MinLevelRst = -16'sd15360;

  typedef enum logic [2:0] {
    REG_DECAY_RATE = 3'd0,
    REG_INT_GAIN = 3'd1,
    REG_PEAK_HOLD = 3'd2,
    REG_INPUT_HOLD = 3'd3,
    REG_IDLE_TIMEOUT = 3'd4,
    REG_MIN_LEVEL = 3'd5
  } reg_idx_t;

  typedef enum logic {
    CMD_LEVELS = 1'b0,
    CMD_REDRAW = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic               ch_ok;
    logic [2:0]         channel;
    logic signed [15:0] magnitude_db;
    logic signed [15:0] peak_db;
    logic signed [15:0] input_peak_db;
    logic [31:0]        timestamp_ms;
    logic [15:0]        elapsed_ms;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [23:0]        decay_rate;
    logic [15:0]        integration_gain;
    logic [23:0]        peak_hold_ms;
    logic [23:0]        input_hold_ms;
    logic [15:0]        idle_timeout_ms;
    logic signed [15:0] minimum_level;
  } cfg_t;

endpackage

// ===== rtl/alm_front.sv =====
module alm_front import alm_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [2:0]         in_channel,
  input  logic signed [15:0] in_magnitude_db,
  input  logic signed [15:0] in_peak_db,
  input  logic signed [15:0] in_input_peak_db,
  input  logic [31:0]        in_timestamp_ms,
  input  logic [15:0]        in_elapsed_ms,
  input  logic               pop,
  output q_head_t            head
);

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  item_t      new_item;

  assign in_stall = (count_r == 2'd2);
  assign push = in_valid && !in_stall;

  // classify on the way in
  always_comb begin
    new_item.command = cmd_t'(in_command);
    new_item.ch_ok = (32'(in_channel) < 32'(NUM_CHANNELS));
    new_item.channel = in_channel;
    new_item.magnitude_db = in_magnitude_db;
    new_item.peak_db = in_peak_db;
    new_item.input_peak_db = in_input_peak_db;
    new_item.timestamp_ms = in_timestamp_ms;
    new_item.elapsed_ms = in_elapsed_ms;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item = q_r[rd_ptr_r];

endmodule

// ===== rtl/alm_back.sv =====
`include "assert_macros.svh"

module alm_back import alm_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  q_head_t            head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_shown_magnitude,
  output logic signed [15:0] out_shown_peak,
  output logic signed [15:0] out_shown_peak_hold,
  output logic signed [15:0] out_shown_input_hold,
  output logic               out_idle
);

  localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [ChIdxW-1:0] LastCh = ChIdxW'(NUM_CHANNELS - 1);

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic upd;
    logic done;
  } ctl_t;

  state_t state_r, state_nxt;
  ctl_t   ctl;
  item_t  it_r;
  logic [ChIdxW-1:0] cnt_r;
  logic [23:0] decay_r;
  logic [31:0] eg_r;
  logic        idle_hit_r;
  logic [47:0] prod_r;
  logic        neg_r;
  logic signed [15:0] res_mag_r, res_peak_r, res_hold_r, res_input_r;
  logic        out_valid_r;
  logic signed [15:0] out_mag_r, out_peak_r, out_hold_r, out_input_r;
  logic        out_idle_r;

  logic signed [15:0] cur_mag_r [NUM_CHANNELS];
  logic signed [15:0] cur_peak_r [NUM_CHANNELS];
  logic signed [15:0] cur_input_r [NUM_CHANNELS];
  logic signed [15:0] disp_mag_r [NUM_CHANNELS];
  logic signed [15:0] disp_peak_r [NUM_CHANNELS];
  logic signed [15:0] hold_peak_r [NUM_CHANNELS];
  logic [31:0]        hold_peak_t_r [NUM_CHANNELS];
  logic signed [15:0] hold_input_r [NUM_CHANNELS];
  logic [31:0]        hold_input_t_r [NUM_CHANNELS];
  logic [31:0]        last_upd_r;

  logic              out_free;
  logic [ChIdxW-1:0] ch_sel;
  logic [15:0]       e_eff;
  logic [39:0]       decay_full;
  logic signed [16:0] diff;
  logic [16:0]       mag;
  logic signed [15:0] cm, cp, ci, dm, dp, hp, hi;
  logic signed [25:0] xp;
  logic signed [33:0] amt, xm, minx;
  logic signed [15:0] np, nm;
  logic              upd_hp, upd_hi;

  assign out_free = !out_valid_r || !out_stall;
  assign ch_sel = ChIdxW'(it_r.channel);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (head.valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (cnt_r == LastCh) ? ST_DONE : ST_MUL;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: ctl.load = head.valid;
      ST_PREP: ctl.prep = 1'b1;
      ST_MUL:  ctl.mul = 1'b1;
      ST_UPD:  ctl.upd = 1'b1;
      ST_DONE: ctl.done = out_free;
      default: ctl = '0;
    endcase
  end

  assign pop = ctl.load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-item products, elapsed time is zero for a levels item
  always_comb begin
    e_eff = (it_r.command == CMD_REDRAW) ? it_r.elapsed_ms : 16'd0;
    decay_full = 40'(cfg.decay_rate) * 40'(e_eff);
  end

  // channel rules, all reads at the sweep counter
  always_comb begin
    cm = cur_mag_r[cnt_r];
    cp = cur_peak_r[cnt_r];
    ci = cur_input_r[cnt_r];
    dm = disp_mag_r[cnt_r];
    dp = disp_peak_r[cnt_r];
    hp = hold_peak_r[cnt_r];
    hi = hold_input_r[cnt_r];

    diff = 17'(cm) - 17'(dm);
    mag = diff[16] ? 17'(-diff) : 17'(diff);

    xp = 26'(dp) - signed'({2'b00, decay_r});
    if (cp >= dp) begin
      np = cp;
    end else if (xp < 26'(cp)) begin
      np = cp;
    end else if (xp > 26'sd0) begin
      np = 16'sd0;
    end else begin
      np = xp[15:0];
    end

    upd_hp = (cp >= hp) || ((it_r.timestamp_ms - hold_peak_t_r[cnt_r]) >
                            32'(cfg.peak_hold_ms));
    upd_hi = (ci >= hi) || ((it_r.timestamp_ms - hold_input_t_r[cnt_r]) >
                            32'(cfg.input_hold_ms));

    amt = signed'({2'b00, prod_r[47:16]});
    xm = 34'(dm) + (neg_r ? -amt : amt);
    minx = 34'(cfg.minimum_level);
    if (dm == MINF) begin
      nm = cm;
    end else if (xm < minx) begin
      nm = cfg.minimum_level;
    end else if (xm > 34'sd0) begin
      nm = 16'sd0;
    end else begin
      nm = xm[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it_r <= head.item;
    end
    if (ctl.prep) begin
      decay_r <= decay_full[39:16];
      eg_r <= 32'(cfg.integration_gain) * 32'(e_eff);
      idle_hit_r <= (it_r.command == CMD_REDRAW) &&
                    ((it_r.timestamp_ms - last_upd_r) > 32'(cfg.idle_timeout_ms));
    end
    if (ctl.mul) begin
      prod_r <= 48'(mag[15:0]) * 48'(eg_r);
      neg_r <= diff[16];
    end
    if (ctl.upd && it_r.ch_ok && (cnt_r == ch_sel)) begin
      res_mag_r <= nm;
      res_peak_r <= np;
      res_hold_r <= upd_hp ? cp : hp;
      res_input_r <= upd_hi ? ci : hi;
    end
    if (ctl.done) begin
      if (idle_hit_r || !it_r.ch_ok) begin
        out_mag_r <= MINF;
        out_peak_r <= MINF;
        out_hold_r <= MINF;
        out_input_r <= MINF;
      end else begin
        out_mag_r <= res_mag_r;
        out_peak_r <= res_peak_r;
        out_hold_r <= res_hold_r;
        out_input_r <= res_input_r;
      end
      out_idle_r <= idle_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.prep) begin
        cnt_r <= '0;
      end else if (ctl.upd && (cnt_r != LastCh)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // channel state, cleared by reset and by a redraw that times out
  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.done && idle_hit_r)) begin
      last_upd_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cur_mag_r[c] <= MINF;
        cur_peak_r[c] <= MINF;
        cur_input_r[c] <= MINF;
        disp_mag_r[c] <= MINF;
        disp_peak_r[c] <= MINF;
        hold_peak_r[c] <= MINF;
        hold_peak_t_r[c] <= '0;
        hold_input_r[c] <= MINF;
        hold_input_t_r[c] <= '0;
      end
    end else begin
      if (ctl.prep && (it_r.command == CMD_LEVELS)) begin
        last_upd_r <= it_r.timestamp_ms;
        if (it_r.ch_ok) begin
          cur_mag_r[ch_sel] <= it_r.magnitude_db;
          cur_peak_r[ch_sel] <= it_r.peak_db;
          cur_input_r[ch_sel] <= it_r.input_peak_db;
        end
      end
      if (ctl.upd) begin
        disp_peak_r[cnt_r] <= np;
        disp_mag_r[cnt_r] <= nm;
        if (upd_hp) begin
          hold_peak_r[cnt_r] <= cp;
          hold_peak_t_r[cnt_r] <= it_r.timestamp_ms;
        end
        if (upd_hi) begin
          hold_input_r[cnt_r] <= ci;
          hold_input_t_r[cnt_r] <= it_r.timestamp_ms;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_shown_magnitude = out_mag_r;
  assign out_shown_peak = out_peak_r;
  assign out_shown_peak_hold = out_hold_r;
  assign out_shown_input_hold = out_input_r;
  assign out_idle = out_idle_r;

  `ALM_ASSERT_IMPL(a_pop_from_idle, pop, (state_r == ST_IDLE) && head.valid)
  `ALM_ASSERT_NEXT(a_done_loads_out, ctl.done, out_valid_r)
  `ALM_ASSERT_NEXT(a_sweep_ends, (state_r == ST_UPD) && (cnt_r == LastCh), state_r == ST_DONE)
  `ALM_ASSERT_IMPL(a_idle_all_minf, out_valid_r && out_idle_r, (out_mag_r == MINF) && (out_hold_r == MINF))

endmodule

// ===== rtl/audio_level_meter_ballistics.sv =====
// per-channel meter ballistics with peak hold
// input channel: in_valid / in_stall, a transfer takes one levels or redraw item;
// a two-entry queue lets the front keep taking items while the back is busy
// every item sweeps all channels one at a time, with a multiply state and then
// an update state per channel; the back loads the item in idle, runs prep, the
// sweep and done, and takes no new item before done; done loads the output
// register and sets out_valid
// result channel: out_valid / out_stall, one result per item holding the
// addressed channel's shown values and the idle flag
// a stalled result holds in the output register; the back waits only when a
// further result is ready and the register is still full
// configuration: apb-style, registers at byte addresses 0 to 20, pready tied
// high; to be written by the user only while no item is in flight, unchecked here
// reset (rst_n low, synchronous) empties the queue, sets every level to minus
// infinity, every time stamp to zero and the registers to their defaults
module audio_level_meter_ballistics import alm_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [2:0]         in_channel,
  input  logic signed [15:0] in_magnitude_db,
  input  logic signed [15:0] in_peak_db,
  input  logic signed [15:0] in_input_peak_db,
  input  logic [31:0]        in_timestamp_ms,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_shown_magnitude,
  output logic signed [15:0] out_shown_peak,
  output logic signed [15:0] out_shown_peak_hold,
  output logic signed [15:0] out_shown_input_hold,
  output logic               out_idle
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;
  q_head_t  head;
  logic     pop;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_rate <= DecayRateRst;
      cfg_r.integration_gain <= IntGainRst;
      cfg_r.peak_hold_ms <= PeakHoldRst;
      cfg_r.input_hold_ms <= InputHoldRst;
      cfg_r.idle_timeout_ms <= IdleTimeoutRst;
      cfg_r.minimum_level <= MinLevelRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_DECAY_RATE:   cfg_r.decay_rate <= pwdata[23:0];
        REG_INT_GAIN:     cfg_r.integration_gain <= pwdata[15:0];
        REG_PEAK_HOLD:    cfg_r.peak_hold_ms <= pwdata[23:0];
        REG_INPUT_HOLD:   cfg_r.input_hold_ms <= pwdata[23:0];
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ms <= pwdata[15:0];
        REG_MIN_LEVEL:    cfg_r.minimum_level <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DECAY_RATE:   prdata = 32'(cfg_r.decay_rate);
      REG_INT_GAIN:     prdata = 32'(cfg_r.integration_gain);
      REG_PEAK_HOLD:    prdata = 32'(cfg_r.peak_hold_ms);
      REG_INPUT_HOLD:   prdata = 32'(cfg_r.input_hold_ms);
      REG_IDLE_TIMEOUT: prdata = 32'(cfg_r.idle_timeout_ms);
      REG_MIN_LEVEL:    prdata = 32'(cfg_r.minimum_level);
      default:          prdata = 32'd0;
    endcase
  end

  alm_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_channel(in_channel),
    .in_magnitude_db(in_magnitude_db),
    .in_peak_db(in_peak_db),
    .in_input_peak_db(in_input_peak_db),
    .in_timestamp_ms(in_timestamp_ms),
    .in_elapsed_ms(in_elapsed_ms),
    .pop(pop),
    .head(head)
  );

  alm_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .head(head),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_shown_magnitude(out_shown_magnitude),
    .out_shown_peak(out_shown_peak),
    .out_shown_peak_hold(out_shown_peak_hold),
    .out_shown_input_hold(out_shown_input_hold),
    .out_idle(out_idle)
  );

endmodule
